// ===== design/bsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsw_pkg: shared types and constants of the B-spline basis weight unit
// Holds the register indexes, the order codes and the piece coefficient
// table with its row lookup.
// ----------------------------------------------------------------------------
package bsw_pkg;

  localparam int unsigned MaxControlDef = 256;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned UW      = 17;
  localparam int unsigned WW      = 17;
  localparam int unsigned OrderW  = 2;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned RowW    = 5;
  localparam int unsigned CoefW   = 9;

  localparam logic [CfgAddrW-1:0] RegOrder = 1'b0;
  localparam logic [CfgAddrW-1:0] RegCount = 1'b1;

  localparam logic [OrderW-1:0] OrderConst = 2'd0;
  localparam logic [OrderW-1:0] OrderLin   = 2'd1;
  localparam logic [OrderW-1:0] OrderQuad  = 2'd2;
  localparam logic [OrderW-1:0] OrderCubic = 2'd3;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef struct packed {
    coef_t a3;
    coef_t a2;
    coef_t a1;
    coef_t a0;
  } poly_t;

  function automatic poly_t poly_row(input logic [RowW-1:0] row);
    poly_t p;
    p = '{a3: 9'sd0, a2: 9'sd0, a1: 9'sd0, a0: 9'sd0};
    unique case (row)
      5'd0:  p = '{ 9'sd0,   9'sd0,   9'sd0,    9'sd12};
      5'd1:  p = '{ 9'sd0,   9'sd0,  -9'sd12,   9'sd12};
      5'd2:  p = '{ 9'sd0,   9'sd0,   9'sd12,   9'sd0};
      5'd3:  p = '{ 9'sd0,   9'sd0,  -9'sd12,   9'sd24};
      5'd4:  p = '{ 9'sd0,   9'sd12, -9'sd24,   9'sd12};
      5'd5:  p = '{ 9'sd0,  -9'sd18,  9'sd24,   9'sd0};
      5'd6:  p = '{ 9'sd0,   9'sd6,  -9'sd24,   9'sd24};
      5'd7:  p = '{ 9'sd0,   9'sd6,   9'sd0,    9'sd0};
      5'd8:  p = '{ 9'sd0,  -9'sd12,  9'sd36,  -9'sd18};
      5'd9:  p = '{ 9'sd0,   9'sd6,  -9'sd36,   9'sd54};
      5'd10: p = '{ 9'sd0,  -9'sd18,  9'sd48,  -9'sd24};
      5'd11: p = '{ 9'sd0,   9'sd12,  9'sd0,    9'sd0};
      5'd12: p = '{-9'sd12,  9'sd36, -9'sd36,   9'sd12};
      5'd13: p = '{ 9'sd21, -9'sd54,  9'sd36,   9'sd0};
      5'd14: p = '{-9'sd3,   9'sd18, -9'sd36,   9'sd24};
      5'd15: p = '{-9'sd11,  9'sd18,  9'sd0,    9'sd0};
      5'd16: p = '{ 9'sd7,  -9'sd36,  9'sd54,  -9'sd18};
      5'd17: p = '{-9'sd2,   9'sd18, -9'sd54,   9'sd54};
      5'd18: p = '{ 9'sd2,   9'sd0,   9'sd0,    9'sd0};
      5'd19: p = '{-9'sd6,   9'sd24, -9'sd24,   9'sd8};
      5'd20: p = '{ 9'sd6,  -9'sd48,  9'sd120, -9'sd88};
      5'd21: p = '{-9'sd2,   9'sd24, -9'sd96,   9'sd128};
      5'd22: p = '{-9'sd7,   9'sd27, -9'sd27,   9'sd9};
      5'd23: p = '{ 9'sd11, -9'sd81,  9'sd189, -9'sd135};
      5'd24: p = '{ 9'sd3,   9'sd0,   9'sd0,    9'sd0};
      5'd25: p = '{-9'sd21,  9'sd72, -9'sd72,   9'sd24};
      5'd26: p = '{ 9'sd12,  9'sd0,   9'sd0,    9'sd0};
      default: p = '{9'sd0, 9'sd0, 9'sd0, 9'sd0};
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== design/bsw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsw_front: classifier
// Forms the normalized offset t over two stages and picks the piece row.
// ----------------------------------------------------------------------------
module bsw_front #(
  parameter int unsigned MaxControl = bsw_pkg::MaxControlDef,
  parameter int unsigned FracBits   = bsw_pkg::FracBitsDef,
  parameter int unsigned TW         = FracBits + 12
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire [bsw_pkg::OrderW-1:0]     order_i,
  input  wire [bsw_pkg::CountW-1:0]     count_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [bsw_pkg::IdxW-1:0]       index_i,
  input  wire [FracBits:0]              u_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic                          out_hit_o,
  output logic [bsw_pkg::RowW-1:0]      out_row_o,
  output logic signed [TW-1:0]          out_t_o
);
  import bsw_pkg::*;

  localparam int unsigned CntW =
      $clog2(MaxControl + 1) > CountW ? $clog2(MaxControl + 1) : CountW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxControl);

  // stage 1: m and k, stage 2: t and row
  logic              v1_q, v2_q;
  logic [OrderW-1:0] ord1_q;
  logic [CntW-1:0]   n1_q;
  logic [IdxW-1:0]   i1_q;
  logic [FracBits:0] u1_q;
  logic [CntW-1:0]   m1_q;
  logic [IdxW-1:0]   k1_q;
  logic              ok1_q;
  logic              adv1, adv2;

  logic [CntW-1:0]   n_sat;
  logic [CntW:0]     idx_ext;

  assign adv2 = !v2_q || !out_stall_i;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_comb begin
    n_sat = (CntW'(count_i) > MaxCnt) ? MaxCnt : CntW'(count_i);
    idx_ext = (CntW + 1)'(index_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      ord1_q <= order_i;
      n1_q   <= n_sat;
      i1_q   <= index_i;
      u1_q   <= u_i;
      m1_q   <= n_sat - CntW'(order_i);
      k1_q   <= (index_i > IdxW'(order_i)) ? index_i - IdxW'(order_i) : '0;
      ok1_q  <= (n_sat >= CntW'(order_i) + CntW'(1)) && (idx_ext < {1'b0, n_sat});
    end
  end

  // stage 2 logic
  logic signed [TW-1:0] t;
  logic [CntW:0]        i2, n2;
  logic [RowW-1:0]      row;
  logic                 hit;
  logic p0, p1, p2, p3, c0, c1, c2;
  localparam logic signed [TW-1:0] O1 = TW'(1) <<< FracBits;

  always_comb begin
    t = $signed(TW'(u1_q)) * $signed(TW'(m1_q))
        - ($signed(TW'(k1_q)) <<< FracBits);
    i2 = (CntW + 1)'(i1_q);
    n2 = (CntW + 1)'(n1_q);
    p0 = t >= 0 && t < O1;
    p1 = t >= O1 && t < 2 * O1;
    p2 = t >= 2 * O1 && t < 3 * O1;
    p3 = t >= 3 * O1 && t < 4 * O1;
    c0 = t >= 0 && t <= O1;
    c1 = t >= O1 && t <= 2 * O1;
    c2 = t >= 2 * O1 && t <= 3 * O1;
    hit = 1'b0;
    row = '0;
    unique case (ord1_q)
      OrderConst: begin
        hit = p0; row = 5'd0;
      end
      OrderLin: begin
        if (i2 == 0) begin
          hit = p0; row = 5'd1;
        end else if (i2 + 1 < n2) begin
          hit = p0 || p1; row = p0 ? 5'd2 : 5'd3;
        end else begin
          hit = c0; row = 5'd2;
        end
      end
      OrderQuad: begin
        if (i2 == 0) begin
          hit = p0; row = 5'd4;
        end else if (i2 == 1) begin
          hit = p0 || p1; row = p0 ? 5'd5 : 5'd6;
        end else if (i2 + 2 < n2) begin
          hit = p0 || p1 || p2; row = p0 ? 5'd7 : (p1 ? 5'd8 : 5'd9);
        end else if (i2 + 2 == n2) begin
          hit = p0 || p1; row = p0 ? 5'd7 : 5'd10;
        end else begin
          hit = p0; row = 5'd11;
        end
      end
      default: begin
        if (i2 == 0) begin
          hit = p0; row = 5'd12;
        end else if (i2 == 1) begin
          hit = p0 || p1; row = p0 ? 5'd13 : 5'd14;
        end else if (i2 == 2) begin
          hit = p0 || p1 || p2; row = p0 ? 5'd15 : (p1 ? 5'd16 : 5'd17);
        end else if (i2 + 3 < n2) begin
          hit = p0 || p1 || p2 || p3;
          row = p0 ? 5'd18 : (p1 ? 5'd19 : (p2 ? 5'd20 : 5'd21));
        end else if (i2 + 3 == n2) begin
          hit = p0 || p1 || c2; row = p0 ? 5'd18 : (p1 ? 5'd22 : 5'd23);
        end else if (i2 + 2 == n2) begin
          hit = p0 || c1; row = p0 ? 5'd24 : 5'd25;
        end else begin
          hit = c0; row = 5'd26;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      out_hit_o <= hit && ok1_q;
      out_row_o <= row;
      out_t_o   <= t;
    end
  end

  assign out_valid_o = v2_q;

endmodule
`default_nettype wire

// ===== design/bsw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsw_queue: two-entry queue between classifier and evaluator
// ----------------------------------------------------------------------------
module bsw_queue #(
  parameter int unsigned W = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire [W-1:0]  in_data_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output logic [W-1:0] out_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign in_stall_o  = cnt_q == 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
endmodule
`default_nettype wire

// ===== design/bsw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsw_back: polynomial evaluator
// Horner's rule over three stages, then divide by 12 and saturate.
// ----------------------------------------------------------------------------
module bsw_back #(
  parameter int unsigned FracBits = bsw_pkg::FracBitsDef,
  parameter int unsigned TW       = FracBits + 12
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire                       in_hit_i,
  input  wire [bsw_pkg::RowW-1:0]   in_row_i,
  input  wire signed [TW-1:0]       in_t_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic [FracBits:0]         out_weight_o
);
  import bsw_pkg::*;

  localparam int unsigned HW = FracBits + 14;
  localparam int unsigned PW = HW + TW;
  // divide by 12 as a shift by 2 and a reciprocal multiply by 1/3
  localparam int unsigned DivK = FracBits + 4;
  localparam int unsigned YW   = FracBits + 2;
  localparam int unsigned RcpW = DivK - 1;
  localparam int unsigned MW   = YW + RcpW;
  localparam logic [RcpW-1:0] Recip3 = RcpW'(((64'd1 << DivK) + 64'd2) / 64'd3);
  localparam logic signed [HW-1:0] Twelve = HW'(12) <<< FracBits;
  localparam logic [FracBits:0] One = {1'b1, FracBits'(0)};

  logic [3:0]             v_q;
  logic                   hit_q [4];
  logic signed [TW-1:0]   t_q [3];
  poly_t                  c_q [3];
  logic signed [HW-1:0]   h1_q, h2_q, h3_q;
  logic [FracBits:0]      weight;
  logic                   adv;

  assign adv = !v_q[3] || !out_stall_i;
  assign in_stall_o = !adv;

  logic signed [PW-1:0] p1, p2, p3;
  logic [YW-1:0]        y;
  logic [MW-1:0]        prod;

  always_comb begin
    p1 = PW'(c_q[0].a3) * PW'(t_q[0]);
    p2 = PW'(h1_q) * PW'(t_q[1]);
    p3 = PW'(h2_q) * PW'(t_q[2]);
    y = h3_q[FracBits+3:2];
    prod = MW'(y) * MW'(Recip3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q[0] <= in_hit_i;
      t_q[0]   <= in_t_i;
      c_q[0]   <= poly_row(in_row_i);
      hit_q[1] <= hit_q[0]; t_q[1] <= t_q[0]; c_q[1] <= c_q[0];
      h1_q     <= HW'(p1) + (HW'(c_q[0].a2) <<< FracBits);
      hit_q[2] <= hit_q[1]; t_q[2] <= t_q[1]; c_q[2] <= c_q[1];
      h2_q     <= HW'(p2 >>> FracBits) + (HW'(c_q[1].a1) <<< FracBits);
      hit_q[3] <= hit_q[2];
      h3_q     <= HW'(p3 >>> FracBits) + (HW'(c_q[2].a0) <<< FracBits);
    end
  end

  // at or above 12.0 the quotient reaches 1.0, so saturate before dividing
  always_comb begin
    if (!hit_q[3] || h3_q <= 0) weight = '0;
    else if (h3_q >= Twelve) weight = One;
    else weight = {1'b0, prod[DivK +: FracBits]};
  end

  assign out_valid_o  = v_q[3];
  assign out_weight_o = weight;
endmodule
`default_nettype wire

// ===== design/bspline_basis_weight_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspline_basis_weight_unit: clamped uniform B-spline basis weight
// Returns the weight of one control point at curve parameter u.
// ----------------------------------------------------------------------------
// One word in, one weight word out, one word per cycle sustained while the
// output does not stall. Seven register stages: two classifier stages (offset
// terms, then offset multiply and piece select), one queue slot, a coefficient
// fetch stage and three Horner stages; the divide by 12 and saturate sit behind
// the last Horner stage. A weight word is offered once its input word has
// passed them, later only on output stall. A two-entry queue lets classifier
// and evaluator stall independently. Write order and count only while idle.
module bspline_basis_weight_unit #(
  parameter int unsigned MaxControl = bsw_pkg::MaxControlDef,
  parameter int unsigned FracBits   = bsw_pkg::FracBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [bsw_pkg::CfgAddrW-1:0]  cfg_index_i,
  input  wire [bsw_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [bsw_pkg::IdxW-1:0]      control_index_i,
  input  wire [FracBits:0]             param_u_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [FracBits:0]            basis_weight_o
);
  import bsw_pkg::*;

  localparam int unsigned TW = FracBits + 12;
  localparam int unsigned QDW = 1 + RowW + TW;

  logic [OrderW-1:0] order_q;
  logic [CountW-1:0] count_q;

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderCubic;
      count_q <= CountW'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegOrder: order_q <= cfg_data_i[OrderW-1:0];
        RegCount: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic              f_valid, f_stall, f_hit;
  logic [RowW-1:0]   f_row;
  logic signed [TW-1:0] f_t;
  logic              b_valid, b_stall;
  logic [QDW-1:0]    b_data;

  bsw_front #(.MaxControl(MaxControl), .FracBits(FracBits), .TW(TW)) u_front (
    .clk_i, .rst_ni, .order_i(order_q), .count_i(count_q),
    .in_valid_i, .in_stall_o, .index_i(control_index_i), .u_i(param_u_i),
    .out_valid_o(f_valid), .out_stall_i(f_stall),
    .out_hit_o(f_hit), .out_row_o(f_row), .out_t_o(f_t)
  );

  bsw_queue #(.W(QDW)) u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_stall_o(f_stall),
    .in_data_i({f_hit, f_row, f_t}),
    .out_valid_o(b_valid), .out_stall_i(b_stall), .out_data_o(b_data)
  );

  bsw_back #(.FracBits(FracBits), .TW(TW)) u_back (
    .clk_i, .rst_ni, .in_valid_i(b_valid), .in_stall_o(b_stall),
    .in_hit_i(b_data[QDW-1]), .in_row_i(b_data[QDW-2 -: RowW]),
    .in_t_i(b_data[TW-1:0]),
    .out_valid_o, .out_stall_i, .out_weight_o(basis_weight_o)
  );
endmodule
`default_nettype wire

// ===== test/bspline_basis_weight_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_basis_weight_unit_tb: self-checking bench for the basis weight unit
// Drives control index / parameter words through the valid-stall handshake,
// predicts each weight with a fixed-point model of the clamped B-spline
// pieces and compares every returned weight in order. Order and count are
// rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module bspline_basis_weight_unit_tb;
  import bsw_pkg::*;

  localparam longint OneQ = 64'sd65536;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_index_i = RegOrder;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [IdxW-1:0] control_index_i = '0;
  logic [UW-1:0] param_u_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [WW-1:0] basis_weight_o;

  bspline_basis_weight_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .control_index_i(control_index_i), .param_u_i(param_u_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .basis_weight_o(basis_weight_o)
  );

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [UW-1:0]   u;
  } query_t;

  query_t pending_words[$];
  logic [WW-1:0] expected_weights[$];
  logic [OrderW-1:0] model_order = OrderCubic;
  logic [CountW-1:0] model_count = 9'd8;
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 70;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor(h*t / 2^16), t nonnegative
  function automatic longint mul_floor(longint h, longint t);
    longint p;
    p = h * t;
    return p >>> 16;
  endfunction

  // Pick the polynomial row; -1 means outside every piece.
  function automatic int piece_row(int ord, longint i, longint n, longint t);
    bit p0, p1, p2, p3, c0, c1, c2;
    p0 = t >= 0 && t < OneQ;
    p1 = t >= OneQ && t < 2 * OneQ;
    p2 = t >= 2 * OneQ && t < 3 * OneQ;
    p3 = t >= 3 * OneQ && t < 4 * OneQ;
    c0 = t >= 0 && t <= OneQ;
    c1 = t >= OneQ && t <= 2 * OneQ;
    c2 = t >= 2 * OneQ && t <= 3 * OneQ;
    if (ord == 0) return p0 ? 0 : -1;
    if (ord == 1) begin
      if (i == 0) return p0 ? 1 : -1;
      if (i < n - 1) return p0 ? 2 : (p1 ? 3 : -1);
      return c0 ? 2 : -1;
    end
    if (ord == 2) begin
      if (i == 0) return p0 ? 4 : -1;
      if (i == 1) return p0 ? 5 : (p1 ? 6 : -1);
      if (i >= 2 && i < n - 2) return p0 ? 7 : (p1 ? 8 : (p2 ? 9 : -1));
      if (i == n - 2) return p0 ? 7 : (p1 ? 10 : -1);
      return p0 ? 11 : -1;
    end
    if (i == 0) return p0 ? 12 : -1;
    if (i == 1) return p0 ? 13 : (p1 ? 14 : -1);
    if (i == 2) return p0 ? 15 : (p1 ? 16 : (p2 ? 17 : -1));
    if (i >= 3 && i < n - 3) return p0 ? 18 : (p1 ? 19 : (p2 ? 20 : (p3 ? 21 : -1)));
    if (i == n - 3) return p0 ? 18 : (p1 ? 22 : (c2 ? 23 : -1));
    if (i == n - 2) return p0 ? 24 : (c1 ? 25 : -1);
    return c0 ? 26 : -1;
  endfunction

  function automatic longint coef_of(int row, int k);
    int tab[27][4];
    tab = '{'{0,0,0,12}, '{0,0,-12,12}, '{0,0,12,0}, '{0,0,-12,24},
            '{0,12,-24,12}, '{0,-18,24,0}, '{0,6,-24,24}, '{0,6,0,0},
            '{0,-12,36,-18}, '{0,6,-36,54}, '{0,-18,48,-24}, '{0,12,0,0},
            '{-12,36,-36,12}, '{21,-54,36,0}, '{-3,18,-36,24}, '{-11,18,0,0},
            '{7,-36,54,-18}, '{-2,18,-54,54}, '{2,0,0,0}, '{-6,24,-24,8},
            '{6,-48,120,-88}, '{-2,24,-96,128}, '{-7,27,-27,9},
            '{11,-81,189,-135}, '{3,0,0,0}, '{-21,72,-72,24}, '{12,0,0,0}};
    return longint'(tab[row][k]);
  endfunction

  function automatic logic [WW-1:0] basis_weight_of(query_t q);
    longint n, i, u, m, k, t, h, w;
    int ord, row;
    ord = int'(model_order);
    n = longint'(model_count);
    i = longint'(q.idx);
    u = longint'(q.u);
    w = 0;
    if (n > 256) n = 256;
    if (n >= ord + 1 && i < n) begin
      m = n - ord;
      k = i - ord;
      if (k < 0) k = 0;
      t = u * m - k * OneQ;
      row = piece_row(ord, i, n, t);
      if (row >= 0) begin
        h = coef_of(row, 0) * t + coef_of(row, 1) * OneQ;
        h = mul_floor(h, t) + coef_of(row, 2) * OneQ;
        h = mul_floor(h, t) + coef_of(row, 3) * OneQ;
        if (h > 0) begin
          w = h / 12;
          if (w > OneQ) w = OneQ;
        end
      end
    end
    return w[WW-1:0];
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Driver: advance to the next word once the current one is taken.
  always @(posedge clk_i) begin
    logic taken;
    taken = in_valid_i && !in_stall_o;
    if (taken) begin
      expected_weights.push_back(
          basis_weight_of('{idx: control_index_i, u: param_u_i}));
    end
    if (!in_valid_i || taken) begin
      if (pending_words.size() != 0 && rst_ni && $urandom_range(99, 0) >= send_idle_pct) begin
        query_t q;
        q = pending_words.pop_front();
        control_index_i <= q.idx;
        param_u_i <= q.u;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  // Monitor: check each weight word against the oldest prediction.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (out_valid_o && !out_stall_i) begin
      if (expected_weights.size() == 0) begin
        report_mismatch($sformatf("unexpected weight %0d", basis_weight_o));
      end else begin
        logic [WW-1:0] e;
        e = expected_weights.pop_front();
        if (basis_weight_o !== e)
          report_mismatch($sformatf("basis_weight got %0d want %0d", basis_weight_o, e));
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_weights.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, int unsigned val);
    cfg_index_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegOrder) model_order = val[OrderW-1:0];
    else model_count = val[CountW-1:0];
  endtask

  task automatic queue_word(int unsigned idx, int unsigned u);
    pending_words.push_back('{idx: idx[IdxW-1:0], u: u[UW-1:0]});
  endtask

  // Mostly in-range indexes and u, a few wild ones and knot-aligned u.
  task automatic queue_random(int unsigned count);
    int unsigned n, sel, idx, u, m;
    n = model_count > 256 ? 256 : model_count;
    m = n > model_order ? n - model_order : 1;
    repeat (count) begin
      sel = $urandom_range(19, 0);
      idx = (sel == 0) ? $urandom_range(255, 0) : $urandom_range(n - 1, 0);
      if (sel == 1) u = $urandom_range(131071, 0);
      else if (sel < 5) u = ($urandom_range(m, 0) * 65536) / m;
      else if (sel == 5) u = 65536;
      else u = $urandom_range(65536, 0);
      queue_word(idx, u);
    end
  endtask

  initial begin
    int unsigned orders[8];
    int unsigned counts[8];
    orders = '{3, 0, 1, 2, 3, 1, 2, 3};
    counts = '{8, 2, 256, 3, 4, 511, 17, 5};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, knot edges, closed high ends at u = 1.
    queue_word(0, 0); queue_word(0, 65536); queue_word(7, 65536);
    queue_word(6, 65536); queue_word(5, 65536); queue_word(255, 131071);
    queue_word(8, 32768); queue_word(3, 21845); queue_word(4, 39322);
    queue_word(1, 13107); queue_word(2, 26214); queue_word(7, 0);
    queue_word(170, 87381);
    drain();
    write_reg(RegOrder, 0); write_reg(RegCount, 5);
    queue_word(4, 65536); queue_word(4, 65535); queue_word(0, 0); queue_word(5, 100);
    drain();
    write_reg(RegOrder, 3); write_reg(RegCount, 3);   // count below order plus one
    queue_word(0, 30000); queue_word(2, 65536);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin send_idle_pct = 9; recv_idle_pct = 70; end
      if (p == 3) begin send_idle_pct = 70; recv_idle_pct = 9; end
      if (p == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(RegOrder, orders[p]);
      write_reg(RegCount, counts[p]);
      queue_random(95);
      drain();            // sender holds until every weight is back
      queue_random(95);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== bspline_basis_weight_unit.f =====
design/bsw_pkg.sv
design/bsw_front.sv
design/bsw_queue.sv
design/bsw_back.sv
design/bspline_basis_weight_unit.sv
test/bspline_basis_weight_unit_tb.sv
